@@ src/wiorm_pkg.sv @@
package wiorm_pkg;

	localparam int unsigned DEF_HISTORY_DEPTH  = 1024;
	localparam int unsigned DEF_RATE_FRAC_BITS = 16;

	localparam int unsigned NUM_COUNTERS = 6;
	localparam int unsigned NUM_WINDOWS  = 3;
	localparam int unsigned CNT_W        = 64;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned WIN_W        = 16;
	localparam int unsigned CFG_IDX_W    = 2;

	localparam logic [WIN_W-1:0] SHORT_WIN_RESET = 16'd60;
	localparam logic [WIN_W-1:0] MID_WIN_RESET   = 16'd300;
	localparam logic [WIN_W-1:0] LONG_WIN_RESET  = 16'd900;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_WINDOW = 2'd0,
		CFG_MID_WINDOW   = 2'd1,
		CFG_LONG_WINDOW  = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		WIN_SHORT = 2'd0,
		WIN_MID   = 2'd1,
		WIN_LONG  = 2'd2,
		WIN_NONE  = 2'd3
	} window_id_t;

	typedef struct packed {
		logic [TIME_W-1:0] timestamp;
		logic [CNT_W-1:0]  read_sectors;
		logic [CNT_W-1:0]  read_ops;
		logic [CNT_W-1:0]  read_bytes;
		logic [CNT_W-1:0]  write_sectors;
		logic [CNT_W-1:0]  write_ops;
		logic [CNT_W-1:0]  write_bytes;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       window_id;
		logic [CNT_W-1:0] read_sector_rate;
		logic [CNT_W-1:0] read_op_rate;
		logic [CNT_W-1:0] read_byte_rate;
		logic [CNT_W-1:0] write_sector_rate;
		logic [CNT_W-1:0] write_op_rate;
		logic [CNT_W-1:0] write_byte_rate;
		logic             last;
	} out_item_t;

endpackage

@@ src/wiorm_ram.sv @@
module wiorm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/wiorm_div.sv @@
module wiorm_div #(
	parameter int unsigned QW = 80
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [QW-1:0]                  dividend,
	input  logic [wiorm_pkg::TIME_W-1:0]   divisor,
	output logic                           done,
	output logic [QW-1:0]                  quotient
);

	localparam int unsigned TW = wiorm_pkg::TIME_W;
	localparam int unsigned CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] dvd_q;
	logic [QW-1:0] quo_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] dsr_q;
	logic [TW:0]   trial;
	logic          fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, dvd_q[QW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? TW'(trial - {1'b0, dsr_q}) : trial[TW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q) else $error("done without run");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> divisor != '0) else $error("division by zero started");

endmodule

@@ src/windowed_io_rate_meter.sv @@
// after a scan reads every slot of the time ring, the six rates of each window
// are divided in turn when an older sample lies in that window, else zeroed;
// a new sample is taken only once all three windows are output, as in_stall is
// high until then; one divider, one bit per cycle, serves all eighteen rates
// reset: asynchronous, then a clearing pass writes zero to every time ring slot
// while in_stall is held high; configuration writes are taken throughout
module windowed_io_rate_meter #(
	parameter int unsigned HISTORY_DEPTH  = wiorm_pkg::DEF_HISTORY_DEPTH,
	parameter int unsigned RATE_FRAC_BITS = wiorm_pkg::DEF_RATE_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  wiorm_pkg::in_item_t              in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output wiorm_pkg::out_item_t             out_item,
	input  logic                             cfg_we,
	input  logic [wiorm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wiorm_pkg::WIN_W-1:0]      cfg_data
);

	localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
	localparam int unsigned NC  = wiorm_pkg::NUM_COUNTERS;
	localparam int unsigned CW  = wiorm_pkg::CNT_W;
	localparam int unsigned TW  = wiorm_pkg::TIME_W;
	localparam int unsigned WW  = wiorm_pkg::WIN_W;
	localparam int unsigned QW  = CW + RATE_FRAC_BITS;
	localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

	typedef enum logic [7:0] {
		S_CLR   = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_SCAN  = 8'b0000_0100,
		S_DRAIN = 8'b0000_1000,
		S_SEL   = 8'b0001_0000,
		S_FETCH = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     wp_nx;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     idx_s1;
	logic              vld_s1;
	logic [WW-1:0]     win_q   [wiorm_pkg::NUM_WINDOWS];
	logic              found_q [wiorm_pkg::NUM_WINDOWS];
	logic [TW-1:0]     best_t_q[wiorm_pkg::NUM_WINDOWS];
	logic [AW-1:0]     best_a_q[wiorm_pkg::NUM_WINDOWS];
	logic [1:0]        w_q;
	logic [2:0]        c_q;
	logic [2:0]        op_idx;
	logic [TW-1:0]     secs_q;
	logic [CW-1:0]     rate_q  [NC];
	wiorm_pkg::in_item_t in_q;

	logic              accept;
	logic              t_we;
	logic [AW-1:0]     t_waddr;
	logic [TW-1:0]     t_wdata;
	logic [TW-1:0]     t_rdata;
	logic [NC*CW-1:0]  c_wdata;
	logic [NC*CW-1:0]  c_rdata;
	logic [CW-1:0]     cur_cnt [NC];
	logic [CW-1:0]     old_cnt [NC];
	logic [CW-1:0]     delta;
	logic              div_start;
	logic              div_done;
	logic [QW-1:0]     div_quo;
	logic [CW-1:0]     sat_rate;
	logic              zero_case;
	logic              out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign wp_nx    = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
	assign out_free = !out_valid || !out_stall;

	assign cur_cnt[0] = in_q.read_sectors;
	assign cur_cnt[1] = in_q.read_ops;
	assign cur_cnt[2] = in_q.read_bytes;
	assign cur_cnt[3] = in_q.write_sectors;
	assign cur_cnt[4] = in_q.write_ops;
	assign cur_cnt[5] = in_q.write_bytes;
	assign c_wdata = {in_item.write_bytes, in_item.write_ops, in_item.write_sectors,
		in_item.read_bytes, in_item.read_ops, in_item.read_sectors};
	for (genvar g = 0; g < NC; g++) begin : g_old
		assign old_cnt[g] = c_rdata[g*CW +: CW];
	end

	// clearing pass shares the time ring write port with the sample write
	always_comb begin
		t_we    = 1'b0;
		t_waddr = wp_nx;
		t_wdata = in_item.timestamp;
		if (state_q == S_CLR) begin
			t_we    = 1'b1;
			t_waddr = idx_q;
			t_wdata = '0;
		end else if (accept) begin
			t_we = 1'b1;
		end
	end

	wiorm_ram #(.WIDTH(TW), .DEPTH(HISTORY_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (state_q == S_SCAN),
		.raddr (idx_q),
		.rdata (t_rdata)
	);

	wiorm_ram #(.WIDTH(NC*CW), .DEPTH(HISTORY_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_nx),
		.wdata (c_wdata),
		.re    (state_q == S_SEL),
		.raddr (best_a_q[w_q]),
		.rdata (c_rdata)
	);

	assign op_idx    = (state_q == S_FETCH) ? 3'd0 : c_q + 3'd1;
	assign delta     = cur_cnt[op_idx] - old_cnt[op_idx];
	assign div_start = (state_q == S_FETCH) ||
		(state_q == S_DIV && div_done && c_q != 3'(NC - 1));
	assign sat_rate  = ((div_quo >> CW) != '0) ? '1 : div_quo[CW-1:0];
	assign zero_case = !found_q[w_q] || best_t_q[w_q] == in_q.timestamp;

	wiorm_div #(.QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (QW'(delta) << RATE_FRAC_BITS),
		.divisor  (secs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= wiorm_pkg::SHORT_WIN_RESET;
			win_q[1] <= wiorm_pkg::MID_WIN_RESET;
			win_q[2] <= wiorm_pkg::LONG_WIN_RESET;
		end else if (cfg_we) begin
			unique case (wiorm_pkg::cfg_index_t'(cfg_index))
				wiorm_pkg::CFG_SHORT_WINDOW: win_q[0] <= cfg_data;
				wiorm_pkg::CFG_MID_WINDOW:   win_q[1] <= cfg_data;
				wiorm_pkg::CFG_LONG_WINDOW:  win_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			wp_q      <= LAST_SLOT;
			idx_q     <= '0;
			vld_s1    <= 1'b0;
			w_q       <= '0;
			c_q       <= '0;
			out_valid <= 1'b0;
			for (int w = 0; w < 3; w++) begin
				found_q[w] <= 1'b0;
			end
		end else begin
			vld_s1 <= state_q == S_SCAN;
			if (out_free) begin
				out_valid <= state_q == S_OUT;
			end
			// candidate compare, one ring entry a cycle
			if (vld_s1 && t_rdata != '0 && t_rdata <= in_q.timestamp) begin
				for (int w = 0; w < 3; w++) begin
					if ({1'b0, t_rdata} + (TW+1)'(win_q[w]) >= {1'b0, in_q.timestamp} &&
						(!found_q[w] || t_rdata < best_t_q[w])) begin
						found_q[w] <= 1'b1;
					end
				end
			end
			unique case (state_q)
				S_CLR: begin
					if (idx_q == LAST_SLOT) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						wp_q    <= wp_nx;
						idx_q   <= '0;
						state_q <= S_SCAN;
						for (int w = 0; w < 3; w++) begin
							found_q[w] <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_SLOT) begin
						idx_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!vld_s1) begin
						w_q     <= '0;
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					c_q <= '0;
					state_q <= zero_case ? S_OUT : S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (c_q == 3'(NC - 1)) begin
							state_q <= S_OUT;
						end else begin
							c_q <= c_q + 3'd1;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (w_q == 2'(wiorm_pkg::WIN_LONG)) begin
							state_q <= S_IDLE;
						end else begin
							w_q     <= w_q + 2'd1;
							state_q <= S_SEL;
						end
					end
				end
				default: state_q <= S_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_item;
		end
		idx_s1 <= idx_q;
		if (vld_s1 && t_rdata != '0 && t_rdata <= in_q.timestamp) begin
			for (int w = 0; w < 3; w++) begin
				if ({1'b0, t_rdata} + (TW+1)'(win_q[w]) >= {1'b0, in_q.timestamp} &&
					(!found_q[w] || t_rdata < best_t_q[w])) begin
					best_t_q[w] <= t_rdata;
					best_a_q[w] <= idx_s1;
				end
			end
		end
		if (state_q == S_SEL) begin
			secs_q <= in_q.timestamp - best_t_q[w_q];
			if (zero_case) begin
				for (int c = 0; c < NC; c++) begin
					rate_q[c] <= '0;
				end
			end
		end
		if (state_q == S_DIV && div_done) begin
			rate_q[c_q] <= sat_rate;
		end
		if (state_q == S_OUT && out_free) begin
			out_item.window_id         <= w_q;
			out_item.read_sector_rate  <= rate_q[0];
			out_item.read_op_rate      <= rate_q[1];
			out_item.read_byte_rate    <= rate_q[2];
			out_item.write_sector_rate <= rate_q[3];
			out_item.write_op_rate     <= rate_q[4];
			out_item.write_byte_rate   <= rate_q[5];
			out_item.last              <= w_q == 2'(wiorm_pkg::WIN_LONG);
		end
	end

	a_last_is_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last |-> out_item.window_id == 2'(wiorm_pkg::WIN_LONG))
		else $error("last flag on wrong window");

	a_scan_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN && idx_q == '0)
		else $error("scan did not start on transaction");

	a_wp_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> wp_q != $past(wp_q)) else $error("write slot not advanced");

	a_no_div_zero_case: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> secs_q != '0) else $error("rate with zero elapsed time");

endmodule
